// ===== sv/bounded_array_table_engine_defines.svh =====
// Assertion macros used by the table engine RTL.
`ifndef BOUNDED_ARRAY_TABLE_ENGINE_DEFINES_SVH
`define BOUNDED_ARRAY_TABLE_ENGINE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BATE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("table engine assertion failed");
`define BATE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("table engine assertion failed");
`else
`define BATE_ASSERT(lbl, clk, rst_n, prop)
`define BATE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/bate_pkg.sv =====
// Types, constants and helper functions of the table engine.
`default_nettype none

package bate_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int CAP_W  = 7;
  localparam int ADDR_W = 3;

  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(64);
  localparam logic [DATA_W-1:0] NEG_ONE   = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ      = 3'd0,
    CMD_OVERWRITE = 3'd1,
    CMD_APPEND    = 3'd2,
    CMD_REMOVE    = 3'd3,
    CMD_SEARCH    = 3'd4,
    CMD_SWAP      = 3'd5,
    CMD_FILL      = 3'd6
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_READ_WAIT,
    S_WRITE,
    S_APPEND,
    S_SHIFT,
    S_SEARCH,
    S_SW_RA,
    S_SW_RB,
    S_SW_WA,
    S_SW_WB,
    S_FILL,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

  // Zero capacity acts as two; anything above the table depth saturates.
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] raw);
    logic [31:0] w;
    w = 32'(raw);
    if (w == 32'd0) begin
      w = 32'd2;
    end
    if (w > 32'(DEPTH)) begin
      w = 32'(DEPTH);
    end
    return CNT_W'(w);
  endfunction

endpackage

`default_nettype wire

// ===== sv/bate_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module bate_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/bate_cfg.sv =====
// APB register block holding the capacity limit.
`default_nettype none

module bate_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bate_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [bate_pkg::CNT_W-1:0]   cap_o
);

  logic [bate_pkg::CAP_W-1:0] cap_q;
  logic [bate_pkg::CAP_W-1:0] cap_d;
  logic                       reg_hit;

  // Only the word at byte address zero is backed; byte offsets are ignored.
  assign reg_hit = (paddr[2] == 1'b0);

  always_comb begin
    cap_d = cap_q;
    if (psel && penable && pwrite && reg_hit) begin
      cap_d = pwdata[bate_pkg::CAP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= bate_pkg::CAP_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

  assign prdata = reg_hit ? {{(32-bate_pkg::CAP_W){1'b0}}, cap_q} : 32'd0;
  assign pready = 1'b1;
  assign cap_o  = bate_pkg::eff_cap(cap_q);

endmodule

`default_nettype wire

// ===== sv/bate_seq.sv =====
// Command sequencer: decodes a transaction and walks the entry memory.
`default_nettype none
`include "bounded_array_table_engine_defines.svh"

module bate_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bate_pkg::CMD_W-1:0]    command_i,
  input  logic [bate_pkg::IDX_W-1:0]    index_a_i,
  input  logic [bate_pkg::IDX_W-1:0]    index_b_i,
  input  logic [bate_pkg::DATA_W-1:0]   value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bate_pkg::DATA_W-1:0]   out_res_o,
  output logic                          out_err_o,
  output logic [bate_pkg::CNT_W-1:0]    out_count_o,
  output logic                          out_empty_o,
  output logic                          out_full_o,
  input  logic [bate_pkg::CNT_W-1:0]    cap_i,
  output bate_pkg::ram_req_t            ram_req_o,
  input  logic [bate_pkg::DATA_W-1:0]   ram_rdata_i
);

  localparam int CNT_W  = bate_pkg::CNT_W;
  localparam int IDX_W  = bate_pkg::IDX_W;
  localparam int DATA_W = bate_pkg::DATA_W;

  bate_pkg::state_e state_q, state_d, start_state;

  logic [IDX_W-1:0]  ia_q, ia_d, ib_q, ib_d;
  logic [DATA_W-1:0] val_q, val_d, tmp_q, tmp_d;
  logic [DATA_W-1:0] res_q, res_d, res_init;
  logic              err_q, err_d;
  logic [CNT_W-1:0]  count_q, count_d, ptr_q, ptr_d, start_ptr;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_res_q, out_res_d;
  logic              out_err_q, out_err_d;
  logic [CNT_W-1:0]  out_count_q, out_count_d;
  logic              out_empty_q, out_empty_d, out_full_q, out_full_d;

  logic [CNT_W-1:0]  ia_ext, ib_ext, wb_ptr, hit_ptr;
  logic              ok_a, ok_b, cmd_ok, rd_go, hit, walk_end, out_free;

  assign ia_ext   = {1'b0, index_a_i};
  assign ib_ext   = {1'b0, index_b_i};
  assign ok_a     = (ia_ext < count_q) && (ia_ext < cap_i);
  assign ok_b     = (ib_ext < count_q) && (ib_ext < cap_i);
  assign rd_go    = (ptr_q < count_q);
  assign hit      = pend_q && (ram_rdata_i == val_q);
  assign walk_end = !rd_go && !pend_q;
  assign wb_ptr   = ptr_q - CNT_W'(2);
  assign hit_ptr  = ptr_q - CNT_W'(1);
  assign out_free = !out_valid_q || !out_stall_i;

  // Command decode: the first state, the walk start and the preset result.
  always_comb begin
    cmd_ok      = 1'b0;
    start_state = bate_pkg::S_DONE;
    start_ptr   = '0;
    unique case (bate_pkg::cmd_e'(command_i))
      bate_pkg::CMD_READ: begin
        cmd_ok      = ok_a;
        start_state = ok_a ? bate_pkg::S_READ : bate_pkg::S_DONE;
      end
      bate_pkg::CMD_OVERWRITE: begin
        cmd_ok      = ok_a;
        start_state = ok_a ? bate_pkg::S_WRITE : bate_pkg::S_DONE;
      end
      bate_pkg::CMD_APPEND: begin
        cmd_ok      = (count_q < cap_i);
        start_state = cmd_ok ? bate_pkg::S_APPEND : bate_pkg::S_DONE;
      end
      bate_pkg::CMD_REMOVE: begin
        cmd_ok      = ok_a;
        start_state = ok_a ? bate_pkg::S_SHIFT : bate_pkg::S_DONE;
        start_ptr   = ia_ext + CNT_W'(1);
      end
      bate_pkg::CMD_SEARCH: begin
        cmd_ok      = 1'b1;
        start_state = bate_pkg::S_SEARCH;
      end
      bate_pkg::CMD_SWAP: begin
        cmd_ok      = ok_a && ok_b;
        start_state = cmd_ok ? bate_pkg::S_SW_RA : bate_pkg::S_DONE;
      end
      bate_pkg::CMD_FILL: begin
        cmd_ok      = 1'b1;
        start_state = bate_pkg::S_FILL;
      end
      default: begin
        cmd_ok      = 1'b0;
        start_state = bate_pkg::S_DONE;
      end
    endcase
    // A rejected command reads as all ones; a search starts as a miss and is overwritten on a hit.
    if (!cmd_ok || (bate_pkg::cmd_e'(command_i) == bate_pkg::CMD_SEARCH)) begin
      res_init = bate_pkg::NEG_ONE;
    end else begin
      res_init = '0;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bate_pkg::S_IDLE:      if (in_valid_i) state_d = start_state;
      bate_pkg::S_READ:      state_d = bate_pkg::S_READ_WAIT;
      bate_pkg::S_READ_WAIT: state_d = bate_pkg::S_DONE;
      bate_pkg::S_WRITE:     state_d = bate_pkg::S_DONE;
      bate_pkg::S_APPEND:    state_d = bate_pkg::S_DONE;
      bate_pkg::S_SHIFT:     if (walk_end) state_d = bate_pkg::S_DONE;
      bate_pkg::S_SEARCH:    if (hit || walk_end) state_d = bate_pkg::S_DONE;
      bate_pkg::S_SW_RA:     state_d = bate_pkg::S_SW_RB;
      bate_pkg::S_SW_RB:     state_d = bate_pkg::S_SW_WA;
      bate_pkg::S_SW_WA:     state_d = bate_pkg::S_SW_WB;
      bate_pkg::S_SW_WB:     state_d = bate_pkg::S_DONE;
      bate_pkg::S_FILL:      if (!rd_go) state_d = bate_pkg::S_DONE;
      bate_pkg::S_DONE:      if (out_free) state_d = bate_pkg::S_IDLE;
      default:               state_d = bate_pkg::S_IDLE;
    endcase
  end

  // Memory requests and datapath.
  always_comb begin
    ia_d        = ia_q;
    ib_d        = ib_q;
    val_d       = val_q;
    tmp_d       = tmp_q;
    res_d       = res_q;
    err_d       = err_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    pend_d      = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_res_d   = out_res_q;
    out_err_d   = out_err_q;
    out_count_d = out_count_q;
    out_empty_d = out_empty_q;
    out_full_d  = out_full_q;
    ram_req_o   = '0;
    unique case (state_q)
      bate_pkg::S_IDLE: begin
        if (in_valid_i) begin
          ia_d  = index_a_i;
          ib_d  = index_b_i;
          val_d = value_i;
          ptr_d = start_ptr;
          res_d = res_init;
          err_d = !cmd_ok;
        end
      end
      bate_pkg::S_READ: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = ia_q;
      end
      bate_pkg::S_READ_WAIT: begin
        res_d = ram_rdata_i;
      end
      bate_pkg::S_WRITE: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = ia_q;
        ram_req_o.wdata = val_q;
      end
      bate_pkg::S_APPEND: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = count_q[IDX_W-1:0];
        ram_req_o.wdata = val_q;
        count_d         = count_q + CNT_W'(1);
      end
      bate_pkg::S_SHIFT: begin
        // Read entry ptr while the entry read in the previous cycle lands one slot lower.
        ram_req_o.re    = rd_go;
        ram_req_o.raddr = ptr_q[IDX_W-1:0];
        pend_d          = rd_go;
        if (rd_go) begin
          ptr_d = ptr_q + CNT_W'(1);
        end
        if (pend_q) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = wb_ptr[IDX_W-1:0];
          ram_req_o.wdata = ram_rdata_i;
        end
        if (walk_end) begin
          count_d = count_q - CNT_W'(1);
        end
      end
      bate_pkg::S_SEARCH: begin
        ram_req_o.re    = rd_go;
        ram_req_o.raddr = ptr_q[IDX_W-1:0];
        pend_d          = rd_go && !hit;
        if (rd_go) begin
          ptr_d = ptr_q + CNT_W'(1);
        end
        if (hit) begin
          res_d = {{(DATA_W-CNT_W){1'b0}}, hit_ptr};
        end
      end
      bate_pkg::S_SW_RA: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = ia_q;
      end
      bate_pkg::S_SW_RB: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = ib_q;
        tmp_d           = ram_rdata_i;
      end
      bate_pkg::S_SW_WA: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = ia_q;
        ram_req_o.wdata = ram_rdata_i;
      end
      bate_pkg::S_SW_WB: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = ib_q;
        ram_req_o.wdata = tmp_q;
      end
      bate_pkg::S_FILL: begin
        if (rd_go) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = ptr_q[IDX_W-1:0];
          ram_req_o.wdata = val_q;
          ptr_d           = ptr_q + CNT_W'(1);
        end
      end
      bate_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          out_err_d   = err_q;
          out_count_d = count_q;
          out_empty_d = (count_q == '0);
          out_full_d  = (count_q >= cap_i);
        end
      end
      default: begin
        pend_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bate_pkg::S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ia_q        <= ia_d;
    ib_q        <= ib_d;
    val_q       <= val_d;
    tmp_q       <= tmp_d;
    res_q       <= res_d;
    err_q       <= err_d;
    ptr_q       <= ptr_d;
    out_res_q   <= out_res_d;
    out_err_q   <= out_err_d;
    out_count_q <= out_count_d;
    out_empty_q <= out_empty_d;
    out_full_q  <= out_full_d;
  end

  assign in_stall_o  = (state_q != bate_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  assign out_err_o   = out_err_q;
  assign out_count_o = out_count_q;
  assign out_empty_o = out_empty_q;
  assign out_full_o  = out_full_q;

  `BATE_ASSERT(a_count_step, clk_i, rst_ni, (count_q != $past(count_q)) |-> ((count_q == $past(count_q) + bate_pkg::CNT_W'(1)) || (count_q == $past(count_q) - bate_pkg::CNT_W'(1))))
  `BATE_ASSERT(a_idle_no_write, clk_i, rst_ni, (state_q == bate_pkg::S_IDLE) |-> !ram_req_o.we)
  `BATE_ASSERT(a_write_in_range, clk_i, rst_ni, ram_req_o.we |-> ({1'b0, ram_req_o.waddr} <= count_q))
  `BATE_ASSERT(a_port_split, clk_i, rst_ni, (ram_req_o.we && ram_req_o.re) |-> (ram_req_o.waddr != ram_req_o.raddr))
  `BATE_ASSERT_NEXT(a_done_loads, clk_i, rst_ni, (state_q == bate_pkg::S_DONE) && !out_valid_q, out_valid_q && (state_q == bate_pkg::S_IDLE))

endmodule

`default_nettype wire

// ===== sv/bounded_array_table_engine.sv =====
// Top level of the bounded table engine: register block, sequencer and entry memory.
//
//   channel   direction  handshake                     payload
//   input     in         in_valid_i / in_stall_o       command_i, index_a_i, index_b_i, value_i
//   result    out        out_valid_o / out_stall_i     result_value_o, error_flag_o,
//                                                      entry_count_o, table_empty_o, is_full_o
//   config    in         psel, penable, pwrite, pready capacity_limit at byte address 0
//
// One transaction is worked at a time; the entry memory, with one write and one read
// port, sets the pace. Fill, remove and search walk the entries one by one, a search
// stops at its first hit, and a rejected command goes straight to its result. The next
// transaction is taken once the result sits in the output register, even while it
// waits to be taken. Reset clears the count; the memory needs no clearing.
`default_nettype none

module bounded_array_table_engine (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [bate_pkg::CMD_W-1:0]           command_i,
  input  logic [bate_pkg::IDX_W-1:0]           index_a_i,
  input  logic [bate_pkg::IDX_W-1:0]           index_b_i,
  input  logic signed [bate_pkg::DATA_W-1:0]   value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [bate_pkg::DATA_W-1:0]   result_value_o,
  output logic                                 error_flag_o,
  output logic [bate_pkg::CNT_W-1:0]           entry_count_o,
  output logic                                 table_empty_o,
  output logic                                 is_full_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bate_pkg::ADDR_W-1:0]          paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  logic [bate_pkg::CNT_W-1:0]  cap;
  bate_pkg::ram_req_t          ram_req;
  logic [bate_pkg::DATA_W-1:0] ram_rdata;
  logic [bate_pkg::DATA_W-1:0] res_raw;

  bate_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap_o   (cap)
  );

  bate_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .index_a_i   (index_a_i),
    .index_b_i   (index_b_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (res_raw),
    .out_err_o   (error_flag_o),
    .out_count_o (entry_count_o),
    .out_empty_o (table_empty_o),
    .out_full_o  (is_full_o),
    .cap_i       (cap),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  bate_ram #(
    .DATA_W (bate_pkg::DATA_W),
    .ADDR_W (bate_pkg::IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  assign result_value_o = $signed(res_raw);

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench of the bounded table engine: directed table, random phases, scoreboard.
module tb_top;

  localparam int DEPTH  = bate_pkg::DEPTH;
  localparam int IDX_W  = bate_pkg::IDX_W;
  localparam int CNT_W  = bate_pkg::CNT_W;
  localparam int DATA_W = bate_pkg::DATA_W;
  localparam int CMD_W  = bate_pkg::CMD_W;
  localparam int CAP_W  = bate_pkg::CAP_W;
  localparam int ADDR_W = bate_pkg::ADDR_W;
  localparam logic [DATA_W-1:0] NEG_ONE = bate_pkg::NEG_ONE;

  localparam logic [CMD_W-1:0]  CMD_UNUSED     = 3'd7;
  localparam logic [ADDR_W-1:0] CAP_LIMIT_ADDR = '0;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 80;
  localparam int HOLD_PHASE    = 4;
  localparam int PAUSE_PHASE   = 2;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  ia;
    logic [IDX_W-1:0]  ib;
    logic [DATA_W-1:0] val;
    logic              known;
    logic [DATA_W-1:0] res;
    logic              err;
    logic [CNT_W-1:0]  cnt;
  } table_row_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              err;
    logic [CNT_W-1:0]  count;
    logic              empty;
    logic              full;
  } table_result_t;

  typedef struct packed {
    logic [31:0] cap_word;
    logic        rand_cap;
    int          send_idle;
    int          recv_stall;
    int          append_pct;
    int          items;
  } phase_t;

  // Rows marked known carry the result word, error flag and count typed in;
  // the others are checked against the shadow table alone.
  localparam table_row_t DIRECTED_ROWS [25] = '{
    '{bate_pkg::CMD_READ,      6'd0,  6'd0,  32'd0,         1'b1, NEG_ONE,       1'b1, 7'd0},
    '{bate_pkg::CMD_SEARCH,    6'd0,  6'd0,  32'd0,         1'b1, NEG_ONE,       1'b0, 7'd0},
    '{bate_pkg::CMD_FILL,      6'd0,  6'd0,  32'd5,         1'b1, 32'd0,         1'b0, 7'd0},
    '{bate_pkg::CMD_REMOVE,    6'd0,  6'd0,  32'd0,         1'b1, NEG_ONE,       1'b1, 7'd0},
    '{bate_pkg::CMD_SWAP,      6'd0,  6'd0,  32'd0,         1'b1, NEG_ONE,       1'b1, 7'd0},
    '{CMD_UNUSED,              6'd0,  6'd0,  32'd0,         1'b1, NEG_ONE,       1'b1, 7'd0},
    '{bate_pkg::CMD_APPEND,    6'd0,  6'd0,  32'h7FFF_FFFF, 1'b1, 32'd0,         1'b0, 7'd1},
    '{bate_pkg::CMD_APPEND,    6'd0,  6'd0,  32'h8000_0000, 1'b1, 32'd0,         1'b0, 7'd2},
    '{bate_pkg::CMD_APPEND,    6'd0,  6'd0,  32'd0,         1'b1, 32'd0,         1'b0, 7'd3},
    '{bate_pkg::CMD_APPEND,    6'd0,  6'd0,  32'hFFFF_FFFF, 1'b1, 32'd0,         1'b0, 7'd4},
    '{bate_pkg::CMD_READ,      6'd1,  6'd0,  32'd0,         1'b1, 32'h8000_0000, 1'b0, 7'd4},
    '{bate_pkg::CMD_READ,      6'd3,  6'd63, 32'hFFFF_FFFF, 1'b0, 32'd0,         1'b0, 7'd0},
    '{bate_pkg::CMD_READ,      6'd63, 6'd0,  32'd0,         1'b1, NEG_ONE,       1'b1, 7'd4},
    '{bate_pkg::CMD_OVERWRITE, 6'd2,  6'd0,  32'h5A5A_5A5A, 1'b0, 32'd0,         1'b0, 7'd0},
    '{bate_pkg::CMD_SEARCH,    6'd0,  6'd0,  32'h5A5A_5A5A, 1'b0, 32'd0,         1'b0, 7'd0},
    '{bate_pkg::CMD_SEARCH,    6'd0,  6'd0,  32'd12345,     1'b0, 32'd0,         1'b0, 7'd0},
    '{bate_pkg::CMD_SWAP,      6'd0,  6'd3,  32'd0,         1'b0, 32'd0,         1'b0, 7'd0},
    '{bate_pkg::CMD_SWAP,      6'd1,  6'd1,  32'd0,         1'b0, 32'd0,         1'b0, 7'd0},
    '{bate_pkg::CMD_SWAP,      6'd0,  6'd63, 32'd0,         1'b1, NEG_ONE,       1'b1, 7'd4},
    '{bate_pkg::CMD_OVERWRITE, 6'd63, 6'd0,  32'd1,         1'b1, NEG_ONE,       1'b1, 7'd4},
    '{bate_pkg::CMD_REMOVE,    6'd1,  6'd0,  32'd0,         1'b0, 32'd0,         1'b0, 7'd0},
    '{bate_pkg::CMD_REMOVE,    6'd2,  6'd0,  32'd0,         1'b0, 32'd0,         1'b0, 7'd0},
    '{bate_pkg::CMD_FILL,      6'd0,  6'd0,  32'hA5A5_A5A5, 1'b0, 32'd0,         1'b0, 7'd0},
    '{CMD_UNUSED,              6'd63, 6'd63, 32'hFFFF_FFFF, 1'b1, NEG_ONE,       1'b1, 7'd2},
    '{bate_pkg::CMD_SEARCH,    6'd0,  6'd0,  32'hA5A5_A5A5, 1'b0, 32'd0,         1'b0, 7'd0}
  };

  localparam phase_t PHASES [8] = '{
    '{32'd127, 1'b0, 0,  0,  70, 130},
    '{32'd0,   1'b0, 45, 0,  40, 90},
    '{32'd1,   1'b0, 0,  45, 35, 90},
    '{32'd5,   1'b0, 9,  9,  45, 100},
    '{32'd40,  1'b0, 0,  0,  60, 110},
    '{32'd0,   1'b1, 45, 0,  50, 100},
    '{32'd64,  1'b0, 0,  45, 70, 120},
    '{32'd2,   1'b0, 9,  9,  30, 80}
  };

  logic                     clk;
  logic                     rst_n      = 1'b0;
  logic                     in_valid   = 1'b0;
  logic                     in_stall_o;
  logic [CMD_W-1:0]         cmd_drv    = '0;
  logic [IDX_W-1:0]         ia_drv     = '0;
  logic [IDX_W-1:0]         ib_drv     = '0;
  logic signed [DATA_W-1:0] value_drv  = '0;
  logic                     out_valid_o;
  logic                     out_stall  = 1'b0;
  logic signed [DATA_W-1:0] result_value_o;
  logic                     error_flag_o;
  logic [CNT_W-1:0]         entry_count_o;
  logic                     table_empty_o;
  logic                     is_full_o;
  logic                     psel       = 1'b0;
  logic                     penable    = 1'b0;
  logic                     pwrite     = 1'b0;
  logic [ADDR_W-1:0]        paddr      = '0;
  logic [31:0]              pwdata     = '0;
  logic [31:0]              prdata;
  logic                     pready;

  // Shadow copy of the table and of the capacity register.
  logic [DATA_W-1:0] shadow_words [DEPTH];
  int                shadow_count   = 0;
  logic [CAP_W-1:0]  shadow_cap_raw = bate_pkg::CAP_RESET;

  table_result_t pending_results [$];
  table_result_t oldest_expected;

  int fail_count     = 0;
  int cycle_count    = 0;
  int items_accepted = 0;
  int error_results  = 0;
  int search_hits    = 0;
  int peak_count     = 0;
  int cap_settings   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int append_pct     = 50;
  int hold_left      = 0;
  bit hold_req       = 1'b0;

  bounded_array_table_engine u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .command_i      (cmd_drv),
    .index_a_i      (ia_drv),
    .index_b_i      (ib_drv),
    .value_i        (value_drv),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .result_value_o (result_value_o),
    .error_flag_o   (error_flag_o),
    .entry_count_o  (entry_count_o),
    .table_empty_o  (table_empty_o),
    .is_full_o      (is_full_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic table_result_t apply_table_command(logic [CMD_W-1:0] cmd,
      logic [IDX_W-1:0] ia, logic [IDX_W-1:0] ib, logic [DATA_W-1:0] val);
    table_result_t r;
    int cap;
    int i;
    bit a_ok;
    bit b_ok;
    bit found;
    logic [DATA_W-1:0] tmp;
    cap = (shadow_cap_raw == 0) ? 2 : ((shadow_cap_raw > DEPTH) ? DEPTH : shadow_cap_raw);
    a_ok = (ia < shadow_count) && (ia < cap);
    b_ok = (ib < shadow_count) && (ib < cap);
    r.value = NEG_ONE;
    r.err = 1'b1;
    case (cmd)
      bate_pkg::CMD_READ: if (a_ok) begin
        r.value = shadow_words[ia];
        r.err = 1'b0;
      end
      bate_pkg::CMD_OVERWRITE: if (a_ok) begin
        shadow_words[ia] = val;
        r.value = '0;
        r.err = 1'b0;
      end
      bate_pkg::CMD_APPEND: if (shadow_count < cap) begin
        shadow_words[shadow_count] = val;
        shadow_count++;
        r.value = '0;
        r.err = 1'b0;
      end
      bate_pkg::CMD_REMOVE: if (a_ok) begin
        for (i = int'(ia); i + 1 < shadow_count; i++) begin
          shadow_words[i] = shadow_words[i + 1];
        end
        shadow_count--;
        r.value = '0;
        r.err = 1'b0;
      end
      bate_pkg::CMD_SEARCH: begin
        r.err = 1'b0;
        found = 1'b0;
        for (i = 0; i < shadow_count; i++) begin
          if (!found && shadow_words[i] == val) begin
            r.value = DATA_W'(i);
            found = 1'b1;
          end
        end
      end
      bate_pkg::CMD_SWAP: if (a_ok && b_ok) begin
        tmp = shadow_words[ia];
        shadow_words[ia] = shadow_words[ib];
        shadow_words[ib] = tmp;
        r.value = '0;
        r.err = 1'b0;
      end
      bate_pkg::CMD_FILL: begin
        for (i = 0; i < shadow_count; i++) begin
          shadow_words[i] = val;
        end
        r.value = '0;
        r.err = 1'b0;
      end
      default: ;
    endcase
    r.count = CNT_W'(shadow_count);
    r.empty = (shadow_count == 0);
    r.full = (shadow_count >= cap);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  // Mostly an occupied slot, so that commands get past the index check.
  function automatic logic [IDX_W-1:0] pick_index();
    if (shadow_count > 0 && $urandom_range(9) < 8) begin
      return IDX_W'($urandom_range(shadow_count - 1));
    end
    return IDX_W'($urandom_range(DEPTH - 1));
  endfunction

  function automatic table_row_t random_row();
    table_row_t row;
    int pick;
    row = '0;
    if ($urandom_range(99) < append_pct) begin
      row.cmd = bate_pkg::CMD_APPEND;
    end else begin
      row.cmd = CMD_W'($urandom_range(7));
    end
    row.ia = pick_index();
    row.ib = pick_index();
    pick = $urandom_range(9);
    if (pick == 0) begin
      case ($urandom_range(3))
        0: row.val = 32'h7FFF_FFFF;
        1: row.val = 32'h8000_0000;
        2: row.val = '0;
        default: row.val = '1;
      endcase
    end else if (pick < 4) begin
      row.val = DATA_W'($urandom_range(15));
    end else if (pick < 7 && shadow_count > 0) begin
      row.val = shadow_words[$urandom_range(shadow_count - 1)];
    end else begin
      row.val = $urandom();
    end
    return row;
  endfunction

  task automatic drive_command(input table_row_t row);
    table_result_t exp;
    cmd_drv   <= row.cmd;
    ia_drv    <= row.ia;
    ib_drv    <= row.ib;
    value_drv <= row.val;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall_o);
    exp = apply_table_command(row.cmd, row.ia, row.ib, row.val);
    if (row.known) begin
      exp.value = row.res;
      exp.err = row.err;
      exp.count = row.cnt;
      exp.empty = (row.cnt == 0);
    end
    items_accepted++;
    error_results += exp.err;
    if (row.cmd == bate_pkg::CMD_SEARCH && exp.value != NEG_ONE) begin
      search_hits++;
    end
    if (shadow_count > peak_count) begin
      peak_count = shadow_count;
    end
    pending_results.push_back(exp);
  endtask

  task automatic sender_gap();
    int n;
    n = 0;
    while ($urandom_range(99) < send_idle_pct) begin
      n++;
    end
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Always waits on the clock before returning, so that valid is never lowered and raised in one step.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic set_capacity(input logic [31:0] wdata);
    wait_drained();
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_LIMIT_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("capacity_limit", 32'(wdata[CAP_W-1:0]), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    shadow_cap_raw = wdata[CAP_W-1:0];
    cap_settings++;
    @(posedge clk);
  endtask

  // Receiver side: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid_o && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no command outstanding: value 0x%08h",
               result_value_o);
        fail_count++;
      end else begin
        oldest_expected = pending_results.pop_front();
        check_field("result_value", oldest_expected.value, result_value_o);
        check_field("error_flag", 32'(oldest_expected.err), 32'(error_flag_o));
        check_field("entry_count", 32'(oldest_expected.count), 32'(entry_count_o));
        check_field("table_empty", 32'(oldest_expected.empty), 32'(table_empty_o));
        check_field("is_full", 32'(oldest_expected.full), 32'(is_full_o));
      end
    end
  end

  // Timeout guard for a run of 845 commands with random gaps and stalls, one long
  // hold-off and the register writes.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Upper bits of the write word are not part of the register.
    set_capacity(32'hFFFF_FF40);
    foreach (DIRECTED_ROWS[k]) begin
      drive_command(DIRECTED_ROWS[k]);
    end
    foreach (PHASES[p]) begin
      set_capacity(PHASES[p].rand_cap ? $urandom() : PHASES[p].cap_word);
      send_idle_pct  = PHASES[p].send_idle;
      recv_stall_pct = PHASES[p].recv_stall;
      append_pct     = PHASES[p].append_pct;
      if (p == HOLD_PHASE) begin
        hold_req = 1'b1;
      end
      for (int n = 0; n < PHASES[p].items; n++) begin
        if (p == PAUSE_PHASE && n == PHASES[p].items / 2) begin
          wait_drained();
        end
        sender_gap();
        drive_command(random_row());
      end
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d table commands under %0d capacity settings; %0d were rejected,",
             items_accepted, cap_settings, error_results);
    $display("%0d searches found a match, and the fill count peaked at %0d of %0d.",
             search_hits, peak_count, DEPTH);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/bate_pkg.sv
sv/bate_ram.sv
sv/bate_cfg.sv
sv/bate_seq.sv
sv/bounded_array_table_engine.sv
tb/tb_top.sv
